// File: rtl/per_source_burst_detector_assert.svh
// Assertion macros for the per-source burst detector.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef PER_SOURCE_BURST_DETECTOR_ASSERT_SVH
`define PER_SOURCE_BURST_DETECTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PBD_ASSERT_IMP(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PBD_ASSERT_NEXT(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/pbd_pkg.sv
// Shared constants and controller/datapath interface types for the burst detector.
// No dependencies.
`default_nettype none

package pbd_pkg;

	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int DEF_HISTORY_DEPTH = 8;

	localparam int ADDR_W   = 32;
	localparam int TIME_W   = 32;
	localparam int TALLY_W  = 4;
	localparam int WINDOW_W = 16;
	localparam int BURST_W  = 4;
	localparam int SLOT_W   = 6;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 16;

	localparam logic [TALLY_W-1:0]  TALLY_MAX    = 4'd15;
	localparam logic [BURST_W-1:0]  BURST_RESET  = 4'd5;
	localparam logic [BURST_W-1:0]  BURST_MIN    = 4'd2;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BURST_COUNT    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 8'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic take_hit;
		logic alloc;
		logic meta_rd;
		logic hist_step;
		logic eval;
		logic full;
		logic emit;
	} pbd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hit;
		logic scan_end;
		logic tbl_full;
		logic out_free;
	} pbd_sts_t;

endpackage

`default_nettype wire

// File: rtl/pbd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module pbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/pbd_ctrl.sv
// Controller state machine for the burst detector: sequences scan, update and output.
// Depends on pbd_pkg.
`default_nettype none

module pbd_ctrl import pbd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire pbd_sts_t  sts,
	output pbd_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_META = 3'd2;
	localparam logic [2:0] S_HIST = 3'd3;
	localparam logic [2:0] S_EVAL = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = S_META;
				end else if (sts.scan_end) begin
					if (sts.tbl_full) begin
						cmd.full = 1'b1;
						state_d  = S_OUT;
					end else begin
						cmd.alloc = 1'b1;
						state_d   = S_META;
					end
				end
			end
			S_META: begin
				cmd.meta_rd = 1'b1;
				state_d     = S_HIST;
			end
			S_HIST: begin
				cmd.hist_step = 1'b1;
				state_d       = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/pbd_dp.sv
// Datapath for the burst detector: config registers, source table scan, history
// update, window check and output register. Depends on pbd_pkg and pbd_ram.
`default_nettype none

module pbd_dp import pbd_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [IN_DATA_W-1:0]  in_data,
	input  wire logic                  out_ready,
	input  wire pbd_cmd_t              cmd,
	output pbd_sts_t                   sts,
	output logic                       out_valid,
	output logic [OUT_DATA_W-1:0]      out_data
);

	localparam int SW     = $clog2(TABLE_ENTRIES);
	localparam int HB     = $clog2(HISTORY_DEPTH);
	localparam int MW     = TALLY_W + HB + 1;
	localparam int HDEPTH = TABLE_ENTRIES * HISTORY_DEPTH;
	localparam int HAW    = $clog2(HDEPTH);

	// Configuration.
	logic [BURST_W-1:0]  burst_q;
	logic [WINDOW_W-1:0] window_q;
	logic [BURST_W-1:0]  burst_eff;

	// Request and scan.
	logic [ADDR_W-1:0] addr_q;
	logic [TIME_W-1:0] time_q;
	logic [SW:0]       fill_q;
	logic [SW:0]       scan_idx_q;
	logic              pend_s1;
	logic [SW-1:0]     idx_s1;
	logic              issue;
	logic              more;

	// Entry update.
	logic [SW-1:0]      slot_q;
	logic               is_new_q;
	logic [HAW-1:0]     base_q;
	logic [HB-1:0]      head_next_q;
	logic [TALLY_W-1:0] tally_new_q;
	logic               flag_old_q;

	// Result holding and output.
	logic              res_susp_q;
	logic              res_newly_q;
	logic              res_full_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// RAM ports.
	logic [ADDR_W-1:0] addr_rd;
	logic [MW-1:0]     meta_rd;
	logic [MW-1:0]     meta_wr;
	logic [TIME_W-1:0] hist_rd;

	// Entry fields at the history step.
	logic [TALLY_W-1:0] tally_c;
	logic [HB-1:0]      head_c;
	logic               flag_c;
	logic [HB:0]        older_sum;
	logic [HB-1:0]      older_idx;
	logic [HB-1:0]      head_next_c;
	logic [TALLY_W-1:0] tally_new_c;

	// Window check.
	logic [TIME_W:0] diff;
	logic            in_window;
	logic            newly;
	logic [4:0]      burst_ext;

	// Clamp the burst length into [2, HISTORY_DEPTH].
	always_comb begin
		burst_ext = {1'b0, burst_q};
		if (burst_q < BURST_MIN) begin
			burst_eff = BURST_MIN;
		end else if (burst_ext > 5'(HISTORY_DEPTH)) begin
			burst_eff = BURST_W'(HISTORY_DEPTH);
		end else begin
			burst_eff = burst_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q  <= BURST_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BURST_COUNT:    burst_q  <= cfg_data[BURST_W-1:0];
				REG_WINDOW_SECONDS: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid entries always form a prefix of the table, so fill_q marks them.
	assign more  = (scan_idx_q < fill_q);
	assign issue = cmd.scan && more;

	assign sts.hit      = pend_s1 && (addr_rd == addr_q);
	assign sts.scan_end = !more && !pend_s1;
	assign sts.tbl_full = (fill_q == (SW+1)'(TABLE_ENTRIES));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			scan_idx_q <= '0;
			pend_s1    <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (cmd.load) begin
				scan_idx_q <= '0;
			end else if (issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (cmd.alloc) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= in_data[ADDR_W-1:0];
			time_q <= in_data[ADDR_W +: TIME_W];
		end
		if (issue) begin
			idx_s1 <= scan_idx_q[SW-1:0];
		end
		if (cmd.take_hit) begin
			slot_q   <= idx_s1;
			is_new_q <= 1'b0;
		end else if (cmd.alloc) begin
			slot_q   <= fill_q[SW-1:0];
			is_new_q <= 1'b1;
		end
		if (cmd.meta_rd) begin
			base_q <= HAW'(slot_q) * HAW'(HISTORY_DEPTH);
		end
	end

	// A fresh entry starts with zero tally, head and flag.
	always_comb begin
		if (is_new_q) begin
			tally_c = '0;
			head_c  = '0;
			flag_c  = 1'b0;
		end else begin
			{tally_c, head_c, flag_c} = meta_rd;
		end
		tally_new_c = (tally_c == TALLY_MAX) ? TALLY_MAX : tally_c + 1'b1;
		head_next_c = (head_c == HB'(HISTORY_DEPTH - 1)) ? '0 : head_c + 1'b1;
		older_sum   = (HB+1)'(head_c) + (HB+1)'(HISTORY_DEPTH)
		            - (HB+1)'(burst_eff - 4'd1);
		if (older_sum >= (HB+1)'(HISTORY_DEPTH)) begin
			older_idx = HB'(older_sum - (HB+1)'(HISTORY_DEPTH));
		end else begin
			older_idx = older_sum[HB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hist_step) begin
			head_next_q <= head_next_c;
			tally_new_q <= tally_new_c;
			flag_old_q  <= flag_c;
		end
	end

	// Signed difference of two unsigned timestamps, one bit wider.
	assign diff      = {1'b0, time_q} - {1'b0, hist_rd};
	assign in_window = $signed(diff) < $signed({{(TIME_W + 1 - WINDOW_W){1'b0}}, window_q});
	assign newly     = !flag_old_q && (tally_new_q >= burst_eff) && in_window;
	assign meta_wr   = {tally_new_q, head_next_q, flag_old_q | newly};

	always_ff @(posedge clk) begin
		if (cmd.full) begin
			res_susp_q  <= 1'b0;
			res_newly_q <= 1'b0;
			res_full_q  <= 1'b1;
			res_slot_q  <= '0;
		end else if (cmd.eval) begin
			res_susp_q  <= flag_old_q | newly;
			res_newly_q <= newly;
			res_full_q  <= 1'b0;
			res_slot_q  <= SLOT_W'(slot_q);
		end
		if (cmd.emit) begin
			out_data_q <= OUT_DATA_W'({res_slot_q, res_full_q, res_newly_q, res_susp_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	pbd_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
		.clk     (clk),
		.wr_en   (cmd.alloc),
		.wr_addr (fill_q[SW-1:0]),
		.wr_data (addr_q),
		.rd_en   (issue),
		.rd_addr (scan_idx_q[SW-1:0]),
		.rd_data (addr_rd)
	);

	pbd_ram #(.WIDTH(MW), .DEPTH(TABLE_ENTRIES)) u_meta_ram (
		.clk     (clk),
		.wr_en   (cmd.eval),
		.wr_addr (slot_q),
		.wr_data (meta_wr),
		.rd_en   (cmd.meta_rd),
		.rd_addr (slot_q),
		.rd_data (meta_rd)
	);

	pbd_ram #(.WIDTH(TIME_W), .DEPTH(HDEPTH)) u_hist_ram (
		.clk     (clk),
		.wr_en   (cmd.hist_step),
		.wr_addr (base_q + HAW'(head_c)),
		.wr_data (time_q),
		.rd_en   (cmd.hist_step),
		.rd_addr (base_q + HAW'(older_idx)),
		.rd_data (hist_rd)
	);

endmodule

`default_nettype wire

// File: rtl/per_source_burst_detector.sv
// Top level of the per-source burst detector: controller, datapath and checks.
// Depends on pbd_pkg, pbd_ctrl, pbd_dp (with pbd_ram) and the assertion macro header.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  source_address, request_time
//   m_axis    out        m_axis_tvalid/m_axis_tready  suspicious, newly_flagged,
//                                                     table_full, entry_slot
//   cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One request at a time. A request is accepted, the address table is scanned up to
// a hit or to the last entry in use (a new source on a full table goes straight to
// output), then the entry metadata is read, the history is stepped, the window is
// checked and the result is emitted once the output register is free;
// the address table scan, one entry per read cycle, grows with the table fill.
// Reset needs no clearing pass: a fill count marks the allocated entries.
// The next request is accepted while a result still waits on m_axis.
`default_nettype none

module per_source_burst_detector import pbd_pkg::*; #(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// s_axis_tdata: [31:0] source_address, [63:32] request_time
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// m_axis_tdata: [0] suspicious, [1] newly_flagged, [2] table_full,
	// [8:3] entry_slot, [15:9] zero
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// configuration write: index 0 burst_count, index 1 window_seconds
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	pbd_cmd_t cmd;
	pbd_sts_t sts;

	// Registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	// Sequence one request through scan, update and output.
	pbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Hold the table, history and the output word.
	pbd_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

`include "per_source_burst_detector_assert.svh"

	// An accepted word always leaves the block busy on the next cycle.
	`PBD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// A dropped request reports nothing but the full mark.
	`PBD_ASSERT_IMP(a_full_word, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[8:0] == 9'd4)
	// A source that was just flagged reads as flagged.
	`PBD_ASSERT_IMP(a_newly_flagged, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[0])

endmodule

`default_nettype wire
